// ----- rtl/core/gdn_pkg.sv -----
package gdn_pkg;

  // Default configuration of the histogram store.
  localparam int unsigned NumOrbitsDef = 73;
  localparam int unsigned MaxDegreeDef = 1024;

  // Fixed field and datapath widths.
  localparam int unsigned OrbitW  = 7;
  localparam int unsigned DegreeW = 16;
  localparam int unsigned CountW  = 24;
  localparam int unsigned ValueW  = 17;
  localparam int unsigned SumW    = 48;
  localparam int unsigned WeightW = 21;
  localparam int unsigned ProdW   = CountW + WeightW;
  localparam int unsigned DivW    = 64;
  localparam int unsigned StepW   = 7;

  localparam logic [CountW-1:0]  CountMax    = '1;
  localparam logic [SumW-1:0]    SumMax      = '1;
  localparam logic [ValueW-1:0]  FracOne     = ValueW'(65536);
  localparam logic [StepW-1:0]   WeightSteps = StepW'(WeightW);
  localparam logic [StepW-1:0]   QuotSteps   = StepW'(DivW);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_DROP = 2'd2
  } status_e;

  typedef enum logic {
    OP_ADD  = 1'b0,
    OP_READ = 1'b1
  } opcode_e;

  // One classified item as it passes from the front end to the back end.
  typedef struct packed {
    opcode_e              op;
    status_e              status;
    logic [OrbitW-1:0]    orbit;
    logic [DegreeW-1:0]   degree;
  } item_t;

endpackage

// ----- rtl/core/gdn_ram.sv -----
module gdn_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/core/gdn_front.sv -----
module gdn_front #(
  parameter int unsigned NumOrbits = gdn_pkg::NumOrbitsDef,
  parameter int unsigned MaxDegree = gdn_pkg::MaxDegreeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         opcode_i,
  input  logic [gdn_pkg::OrbitW-1:0]   orbit_index_i,
  input  logic [gdn_pkg::DegreeW-1:0]  orbit_degree_i,
  input  logic                         clearing_i,
  output logic                         q_valid_o,
  output gdn_pkg::item_t               q_item_o,
  input  logic                         q_pop_i
);
  import gdn_pkg::*;

  item_t       item_in;
  item_t       fifo_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;
  logic        do_push, do_pop;

  // Classify the item as it arrives so that the back end sees a ready status.
  always_comb begin
    item_in.op     = opcode_e'(opcode_i);
    item_in.orbit  = orbit_index_i;
    item_in.degree = orbit_degree_i;
    if (orbit_degree_i == '0) begin
      item_in.status = ST_ZERO;
    end else if ({1'b0, orbit_degree_i} > (DegreeW+1)'(MaxDegree) ||
                 {1'b0, orbit_index_i} >= (OrbitW+1)'(NumOrbits)) begin
      item_in.status = ST_DROP;
    end else begin
      item_in.status = ST_OK;
    end
  end

  assign full_o    = (cnt_q == 2'd2) || clearing_i;
  assign do_push   = push_i && !full_o;
  assign q_valid_o = (cnt_q != 2'd0);
  assign do_pop    = q_pop_i && q_valid_o;
  assign q_item_o  = fifo_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      fifo_q[wr_ptr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

// ----- rtl/core/gdn_back.sv -----
module gdn_back #(
  parameter int unsigned NumOrbits = gdn_pkg::NumOrbitsDef,
  parameter int unsigned MaxDegree = gdn_pkg::MaxDegreeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         norm_en_i,
  output logic                         clearing_o,
  input  logic                         q_valid_i,
  input  gdn_pkg::item_t               q_item_i,
  output logic                         q_pop_o,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [1:0]                   status_o,
  output logic [gdn_pkg::CountW-1:0]   bin_count_o,
  output logic [gdn_pkg::ValueW-1:0]   bin_value_o
);
  import gdn_pkg::*;

  localparam int unsigned Depth  = NumOrbits * MaxDegree;
  localparam int unsigned AddrW  = $clog2(Depth);
  localparam int unsigned OrbAW  = (NumOrbits > 1) ? $clog2(NumOrbits) : 1;

  typedef enum logic [5:0] {
    S_CLR  = 6'b000001,
    S_IDLE = 6'b000010,
    S_WDIV = 6'b000100,
    S_EXEC = 6'b001000,
    S_MUL  = 6'b010000,
    S_QDIV = 6'b100000
  } state_e;

  state_e               state_q, state_d;
  logic [AddrW-1:0]     clr_q, clr_d;
  item_t                item_q, item_d;
  logic                 out_valid_q, out_valid_d;
  status_e              status_q, status_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [ValueW-1:0]    value_q, value_d;
  logic [ProdW-1:0]     prod_q, prod_d;

  logic [SumW-1:0]      rem_q, rem_d;
  logic [SumW-1:0]      dsr_q, dsr_d;
  logic [DivW-1:0]      dvd_q, dvd_d;
  logic [DivW-1:0]      quo_q, quo_d;
  logic [StepW-1:0]     step_q, step_d;

  logic [SumW:0]        trial, diff;
  logic                 ge;
  logic [DivW-1:0]      quo_next;

  logic [AddrW-1:0]     bin_addr;
  logic [OrbAW-1:0]     orb_addr;
  logic [CountW-1:0]    cnt_rd;
  logic [SumW-1:0]      sum_rd;
  logic [WeightW-1:0]   weight;
  logic [SumW:0]        sum_inc;
  logic                 wr_go;
  logic                 clearing;

  logic                 cnt_we, sum_we;
  logic [AddrW-1:0]     cnt_waddr;
  logic [CountW-1:0]    cnt_wdata;
  logic [OrbAW-1:0]     sum_waddr;
  logic [SumW-1:0]      sum_wdata;

  assign clearing   = (state_q == S_CLR);
  assign clearing_o = clearing;

  assign bin_addr = AddrW'(item_q.orbit) * AddrW'(MaxDegree)
                  + AddrW'(item_q.degree) - AddrW'(1);
  assign orb_addr = OrbAW'(item_q.orbit);

  assign weight  = quo_q[WeightW-1:0];
  assign sum_inc = {1'b0, sum_rd} + (SumW+1)'(weight);

  // One restoring division step per cycle.
  assign trial    = {rem_q, dvd_q[DivW-1]};
  assign diff     = trial - {1'b0, dsr_q};
  assign ge       = (trial >= {1'b0, dsr_q});
  assign quo_next = {quo_q[DivW-2:0], ge};

  assign cnt_we    = clearing || wr_go;
  assign cnt_waddr = clearing ? clr_q : bin_addr;
  assign cnt_wdata = clearing ? '0 : cnt_rd + CountW'(1);
  assign sum_we    = (clearing && (clr_q < AddrW'(NumOrbits))) || wr_go;
  assign sum_waddr = clearing ? OrbAW'(clr_q) : orb_addr;
  assign sum_wdata = clearing ? '0 : (sum_inc[SumW] ? SumMax : sum_inc[SumW-1:0]);

  gdn_ram #(.Width(CountW), .Depth(Depth)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .raddr_i (bin_addr),
    .rdata_o (cnt_rd)
  );

  gdn_ram #(.Width(SumW), .Depth(NumOrbits)) u_sum_ram (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (sum_waddr),
    .wdata_i (sum_wdata),
    .raddr_i (orb_addr),
    .rdata_o (sum_rd)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    item_d      = item_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    count_d     = count_q;
    value_d     = value_q;
    prod_d      = prod_q;
    rem_d       = rem_q;
    dsr_d       = dsr_q;
    dvd_d       = dvd_q;
    quo_d       = quo_q;
    step_d      = step_q;
    q_pop_o     = 1'b0;
    wr_go       = 1'b0;

    if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLR: begin
        clr_d = clr_q + AddrW'(1);
        if (clr_q == AddrW'(Depth - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (q_valid_i && !out_valid_q) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          if (q_item_i.status != ST_OK) begin
            out_valid_d = 1'b1;
            status_d    = q_item_i.status;
            count_d     = '0;
            value_d     = '0;
          end else begin
            // Weight 2^20 / k: a lone one bit followed by twenty zero bits.
            rem_d   = '0;
            dvd_d   = {1'b1, {(DivW-1){1'b0}}};
            dsr_d   = SumW'(q_item_i.degree);
            quo_d   = '0;
            step_d  = WeightSteps;
            state_d = S_WDIV;
          end
        end
      end
      S_WDIV, S_QDIV: begin
        rem_d  = ge ? diff[SumW-1:0] : trial[SumW-1:0];
        dvd_d  = {dvd_q[DivW-2:0], 1'b0};
        quo_d  = quo_next;
        step_d = step_q - StepW'(1);
        if (step_q == StepW'(1)) begin
          if (state_q == S_WDIV) begin
            state_d = S_EXEC;
          end else begin
            out_valid_d = 1'b1;
            status_d    = ST_OK;
            count_d     = cnt_rd;
            value_d     = (quo_next > DivW'(FracOne)) ? FracOne : quo_next[ValueW-1:0];
            state_d     = S_IDLE;
          end
        end
      end
      S_EXEC: begin
        status_d = ST_OK;
        value_d  = '0;
        count_d  = cnt_rd;
        if (item_q.op == OP_ADD) begin
          if (cnt_rd != CountMax) begin
            wr_go   = 1'b1;
            count_d = cnt_rd + CountW'(1);
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end else if (norm_en_i && (sum_rd != '0)) begin
          prod_d  = ProdW'(cnt_rd) * ProdW'(weight);
          state_d = S_MUL;
        end else begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      S_MUL: begin
        rem_d   = '0;
        dvd_d   = {{(DivW-ProdW-16){1'b0}}, prod_q, 16'd0};
        dsr_d   = sum_rd;
        quo_d   = '0;
        step_d  = QuotSteps;
        state_d = S_QDIV;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q   <= item_d;
    status_q <= status_d;
    count_q  <= count_d;
    value_q  <= value_d;
    prod_q   <= prod_d;
    rem_q    <= rem_d;
    dsr_q    <= dsr_d;
    dvd_q    <= dvd_d;
    quo_q    <= quo_d;
    step_q   <= step_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign empty_o     = !out_valid_q;
  assign status_o    = status_q;
  assign bin_count_o = count_q;
  assign bin_value_o = value_q;

endmodule

// ----- rtl/core/orbit_degree_histogram_normalizer.sv -----
// Channel  | Direction | Handshake        | Payload
// input    | in        | push_i / full_o  | opcode_i, orbit_index_i, orbit_degree_i
// result   | out       | pop_i / empty_o  | status_o, bin_count_o, bin_value_o
// config   | in        | cfg_we_i         | cfg_wdata_i (normalise enable)
//
// After reset a clearing pass zeroes the count and sum memories, one entry a
// cycle, over NUM_ORBITS * MAX_DEGREE entries (74752 by default); full_o is
// high meanwhile. The back end answers an item with status other than ok
// when it takes it. An add, or a read with normalisation off, passes the
// back end in steps: it takes the item, runs the 21-step serial division that
// forms the weight 2^20 / k, and then does the read-modify-write of the
// memories for an add or the read for a read. A normalised read of a nonzero
// orbit sum adds a multiply step and a 64-step serial division by that sum.
// A two-entry queue in the front end keeps accepting items, until it is full,
// while the back end works or while a result waits to be popped.
module orbit_degree_histogram_normalizer #(
  parameter int unsigned NUM_ORBITS = gdn_pkg::NumOrbitsDef,
  parameter int unsigned MAX_DEGREE = gdn_pkg::MaxDegreeDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic                         opcode_i,
  input  logic [gdn_pkg::OrbitW-1:0]   orbit_index_i,
  input  logic [gdn_pkg::DegreeW-1:0]  orbit_degree_i,
  output logic                         empty_o,
  input  logic                         pop_i,
  output logic [1:0]                   status_o,
  output logic [gdn_pkg::CountW-1:0]   bin_count_o,
  output logic [gdn_pkg::ValueW-1:0]   bin_value_o,
  input  logic                         cfg_we_i,
  input  logic                         cfg_wdata_i
);
  import gdn_pkg::*;

  logic   norm_en_q;
  logic   clearing;
  logic   q_valid;
  logic   q_pop;
  item_t  q_item;

  // The normalise enable must be written only while the block is idle; the
  // block does not enforce it, so the back end may sample it at any point of an item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      norm_en_q <= 1'b0;
    end else if (cfg_we_i) begin
      norm_en_q <= cfg_wdata_i;
    end
  end

  // The front end classifies each item and queues it.
  gdn_front #(.NumOrbits(NUM_ORBITS), .MaxDegree(MAX_DEGREE)) u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push_i         (push_i),
    .full_o         (full_o),
    .opcode_i       (opcode_i),
    .orbit_index_i  (orbit_index_i),
    .orbit_degree_i (orbit_degree_i),
    .clearing_i     (clearing),
    .q_valid_o      (q_valid),
    .q_item_o       (q_item),
    .q_pop_i        (q_pop)
  );

  // The back end owns the memories, the divider and the result register.
  gdn_back #(.NumOrbits(NUM_ORBITS), .MaxDegree(MAX_DEGREE)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .norm_en_i   (norm_en_q),
    .clearing_o  (clearing),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .status_o    (status_o),
    .bin_count_o (bin_count_o),
    .bin_value_o (bin_value_o)
  );

endmodule

// ----- rtl/core/gdn_checker.sv -----
module gdn_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        empty_o,
  input logic        pop_i,
  input logic [1:0]  status_o,
  input logic [23:0] bin_count_o,
  input logic [16:0] bin_value_o
);
  import gdn_pkg::*;

  a_skip_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && status_o != ST_OK) |-> (bin_count_o == '0 && bin_value_o == '0))
    else $error("skipped or dropped item carries data");

  a_frac_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (bin_value_o <= FracOne))
    else $error("fraction above one");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o |-> (status_o == ST_OK || status_o == ST_ZERO || status_o == ST_DROP))
    else $error("unknown status code");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=> (!empty_o && $stable(bin_count_o) && $stable(bin_value_o)))
    else $error("waiting item changed");

endmodule

bind orbit_degree_histogram_normalizer gdn_checker u_gdn_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .empty_o     (empty_o),
  .pop_i       (pop_i),
  .status_o    (status_o),
  .bin_count_o (bin_count_o),
  .bin_value_o (bin_value_o)
);
